>>> rtl/core/rcsfd_pkg.sv
// Shared types and constants for the satellite receiver frame decoder.
// Used by the front queue, the back execution unit and the top level.
`timescale 1ns / 1ps

package rcsfd_pkg;

  localparam logic OP_BYTE = 1'b0;
  localparam logic OP_READ = 1'b1;

  localparam int CFG_INDEX_W = 8;
  localparam int CFG_DATA_W  = 32;

  localparam logic [CFG_INDEX_W-1:0] CFG_HIGH_RES  = 8'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_MIDDLE    = 8'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_CHAN_MAP  = 8'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_GAP_THRES = 8'd3;

  localparam logic        RST_HIGH_RES  = 1'b1;
  localparam logic [11:0] RST_MIDDLE    = 12'd1500;
  localparam logic [20:0] RST_CHAN_MAP  = 21'd1754760;
  localparam logic [15:0] RST_GAP_THRES = 16'd5000;

  localparam logic [11:0] BASE_PULSE = 12'd988;
  localparam int          MAP_FIELDS = 7;

  typedef struct packed {
    logic        high_resolution;
    logic [11:0] middle_value;
    logic [20:0] channel_map;
    logic [15:0] gap_threshold_us;
  } cfg_t;

  typedef struct packed {
    logic        is_read;
    logic [7:0]  rx_byte;
    logic [31:0] time_us;
    logic [3:0]  channel;
  } item_t;

endpackage

>>> rtl/core/rcsfd_front.sv
// Front end of the frame decoder: accepts and classifies input items.
// Holds them in a two-entry queue for the back end; uses rcsfd_pkg.
`timescale 1ns / 1ps

module rcsfd_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  output logic              item_stall,
  input  logic              operation,
  input  logic [7:0]        rx_byte,
  input  logic [31:0]       time_us,
  input  logic [3:0]        channel,
  output logic              q_valid,
  output rcsfd_pkg::item_t  q_item,
  input  logic              q_pop
);
  import rcsfd_pkg::*;

  item_t      entry [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       push;
  item_t      incoming;

  assign item_stall = (count == 2'd2);
  assign push       = item_valid && !item_stall;
  assign q_valid    = (count != 2'd0);
  assign q_item     = entry[rd_ptr];

  always_comb begin
    incoming.is_read = (operation == OP_READ);
    incoming.rx_byte = rx_byte;
    incoming.time_us = time_us;
    incoming.channel = channel;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (q_pop) begin
        rd_ptr <= !rd_ptr;
      end
      if (push && !q_pop) begin
        count <= count + 2'd1;
      end else if (!push && q_pop) begin
        count <= count - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= incoming;
    end
  end

endmodule

>>> rtl/core/rcsfd_back.sv
// Back end of the frame decoder: stores frame bytes, walks the decode and
// answers channel reads into an output register. Uses rcsfd_pkg.
`timescale 1ns / 1ps

module rcsfd_back #(
  parameter int FRAME_BYTES = 16,
  parameter int CHANNELS    = 7
) (
  input  logic              clk,
  input  logic              rst,
  input  rcsfd_pkg::cfg_t   cfg,
  input  logic              q_valid,
  input  rcsfd_pkg::item_t  q_item,
  output logic              q_pop,
  output logic              result_valid,
  input  logic              result_stall,
  output logic [11:0]       channel_value,
  output logic              frame_done
);
  import rcsfd_pkg::*;

  localparam int POS_W     = $clog2(FRAME_BYTES);
  localparam int LAST_WORD = FRAME_BYTES / 2 - 1;
  localparam int WK        = $clog2(LAST_WORD + 1);
  localparam int CH_W      = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  typedef enum logic [1:0] {S_IDLE, S_DEC_RD, S_DEC_WR, S_LOOK} state_t;

  state_t           state;
  logic [7:0]       frame_store [FRAME_BYTES];
  logic [POS_W-1:0] wpos;
  logic [31:0]      last_time;
  logic             pending;
  logic             seen;
  logic [10:0]      chan_vals [CHANNELS];
  logic [WK-1:0]    word;
  logic [3:0]       rd_chan;
  logic [7:0]       rd_hi;
  logic [7:0]       rd_lo;

  logic             out_free;
  logic             load_res;
  logic [31:0]      gap;
  logic [POS_W-1:0] pos_eff;
  logic             at_last;
  logic [POS_W-1:0] wpos_next;
  logic [POS_W-1:0] hi_addr;
  logic [POS_W-1:0] lo_addr;
  logic [3:0]       dec_id;
  logic [10:0]      dec_val;
  logic             id_ok;
  logic [2:0]       map_f [8];
  logic [2:0]       slot;
  logic             look_ok;
  logic [10:0]      look_raw;
  logic [10:0]      look_adj;
  logic [11:0]      look_val;

  assign out_free = !result_valid || !result_stall;
  assign q_pop    = (state == S_IDLE) && q_valid && out_free;
  assign load_res = (q_pop && !q_item.is_read) || ((state == S_LOOK) && out_free);

  assign gap       = q_item.time_us - last_time;
  assign pos_eff   = (gap > {16'd0, cfg.gap_threshold_us}) ? '0 : wpos;
  assign at_last   = (pos_eff == POS_W'(FRAME_BYTES - 1));
  assign wpos_next = at_last ? pos_eff : pos_eff + POS_W'(1);

  assign hi_addr = POS_W'({word, 1'b0});
  assign lo_addr = POS_W'({word, 1'b1});

  assign dec_id  = cfg.high_resolution ? rd_hi[6:3] : rd_hi[5:2];
  assign dec_val = cfg.high_resolution ? {rd_hi[2:0], rd_lo} : {1'b0, rd_hi[1:0], rd_lo};
  assign id_ok   = (dec_id < CHANNELS);

  always_comb begin
    map_f = '{default: '0};
    for (int i = 0; i < MAP_FIELDS; i++) begin
      map_f[i] = cfg.channel_map[3*i +: 3];
    end
  end

  assign slot     = map_f[rd_chan[2:0]];
  assign look_ok  = seen && (rd_chan < CHANNELS) && (rd_chan < MAP_FIELDS) && (slot < CHANNELS);
  assign look_raw = chan_vals[CH_W'(slot)];
  assign look_adj = cfg.high_resolution ? {1'b0, look_raw[10:1]} : look_raw;
  assign look_val = look_ok ? BASE_PULSE + {1'b0, look_adj} : cfg.middle_value;

  always_ff @(posedge clk) begin
    if (q_pop && !q_item.is_read) begin
      frame_store[pos_eff] <= q_item.rx_byte;
    end
    if (state == S_DEC_RD) begin
      rd_hi <= frame_store[hi_addr];
      rd_lo <= frame_store[lo_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      result_valid <= 1'b0;
      wpos         <= '0;
      last_time    <= '0;
      pending      <= 1'b0;
      seen         <= 1'b0;
      word         <= '0;
      for (int i = 0; i < CHANNELS; i++) begin
        chan_vals[i] <= '0;
      end
    end else begin
      if (load_res) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (q_pop) begin
            if (!q_item.is_read) begin
              seen          <= 1'b1;
              last_time     <= q_item.time_us;
              wpos          <= wpos_next;
              if (at_last) begin
                pending <= 1'b1;
              end
              channel_value <= '0;
              frame_done    <= at_last;
            end else begin
              rd_chan <= q_item.channel;
              if (pending) begin
                word  <= WK'(1);
                state <= S_DEC_RD;
              end else begin
                state <= S_LOOK;
              end
            end
          end
        end
        S_DEC_RD: begin
          state <= S_DEC_WR;
        end
        S_DEC_WR: begin
          if (id_ok) begin
            chan_vals[CH_W'(dec_id)] <= dec_val;
          end
          if (word == WK'(LAST_WORD)) begin
            pending <= 1'b0;
            state   <= S_LOOK;
          end else begin
            word  <= word + WK'(1);
            state <= S_DEC_RD;
          end
        end
        S_LOOK: begin
          if (out_free) begin
            channel_value <= look_val;
            frame_done    <= 1'b0;
            state         <= S_IDLE;
          end
        end
      endcase
    end
  end

endmodule

>>> rtl/core/rc_satellite_frame_decoder_top.sv
// Top level of the satellite receiver frame decoder: configuration registers,
// front queue and back execution unit. Uses rcsfd_pkg, rcsfd_front, rcsfd_back.
//
//   Channel  Handshake              Payload
//   item     item_valid/item_stall  operation, rx_byte, time_us, channel
//   result   result_valid/stall     channel_value, frame_done
//   config   cfg_valid/cfg_ready    cfg_index, cfg_data
//
// A byte item waits in the queue until the back end pops it and loads its result.
// A read item ends in S_LOOK; when a completed frame is pending it first walks
// the decode one word per step, S_DEC_RD then S_DEC_WR, for words 1 to FRAME_BYTES/2 - 1.
// Reset is synchronous and clears all control state and the channel values.
// A stalled result holds in the output register; the queue takes items until both entries fill.
`timescale 1ns / 1ps

module rc_satellite_frame_decoder_top #(
  parameter int FRAME_BYTES = 16,
  parameter int CHANNELS    = 7
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                item_valid,
  output logic                                item_stall,
  input  logic                                operation,
  input  logic [7:0]                          rx_byte,
  input  logic [31:0]                         time_us,
  input  logic [3:0]                          channel,
  output logic                                result_valid,
  input  logic                                result_stall,
  output logic [11:0]                         channel_value,
  output logic                                frame_done,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [rcsfd_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [rcsfd_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import rcsfd_pkg::*;

  cfg_t  cfg;
  logic  q_valid;
  item_t q_item;
  logic  q_pop;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.high_resolution  <= RST_HIGH_RES;
      cfg.middle_value     <= RST_MIDDLE;
      cfg.channel_map      <= RST_CHAN_MAP;
      cfg.gap_threshold_us <= RST_GAP_THRES;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_HIGH_RES:  cfg.high_resolution  <= cfg_data[0];
        CFG_MIDDLE:    cfg.middle_value     <= cfg_data[11:0];
        CFG_CHAN_MAP:  cfg.channel_map      <= cfg_data[20:0];
        CFG_GAP_THRES: cfg.gap_threshold_us <= cfg_data[15:0];
        default: begin
        end
      endcase
    end
  end

  rcsfd_front u_front (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .operation  (operation),
    .rx_byte    (rx_byte),
    .time_us    (time_us),
    .channel    (channel),
    .q_valid    (q_valid),
    .q_item     (q_item),
    .q_pop      (q_pop)
  );

  rcsfd_back #(
    .FRAME_BYTES (FRAME_BYTES),
    .CHANNELS    (CHANNELS)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .cfg           (cfg),
    .q_valid       (q_valid),
    .q_item        (q_item),
    .q_pop         (q_pop),
    .result_valid  (result_valid),
    .result_stall  (result_stall),
    .channel_value (channel_value),
    .frame_done    (frame_done)
  );

endmodule

>>> dv/testbench.sv
// Self-checking testbench for rc_satellite_frame_decoder_top: it drives byte and
// read items, predicts every result and checks each one in order.
// Depends on rcsfd_pkg and the RTL under rtl/core.
`timescale 1ns / 1ps

class channel_readout_predictor;
  localparam int FRAME_LEN = 16;
  localparam int NUM_CHANNELS = 7;

  typedef struct {
    logic [11:0] value;
    logic        done;
  } readout_t;

  rcsfd_pkg::cfg_t cfg;
  logic [7:0]      frame_bytes [FRAME_LEN];
  int unsigned     wr_pos;
  logic [31:0]     last_stamp;
  bit              frame_ready;
  bit              any_byte;
  logic [10:0]     chan_words [NUM_CHANNELS];
  readout_t        pending_readouts [$];
  int              errors;

  function new();
    cfg.high_resolution  = rcsfd_pkg::RST_HIGH_RES;
    cfg.middle_value     = rcsfd_pkg::RST_MIDDLE;
    cfg.channel_map      = rcsfd_pkg::RST_CHAN_MAP;
    cfg.gap_threshold_us = rcsfd_pkg::RST_GAP_THRES;
    foreach (frame_bytes[i]) frame_bytes[i] = '0;
    foreach (chan_words[i]) chan_words[i] = '0;
    wr_pos      = 0;
    last_stamp  = '0;
    frame_ready = 0;
    any_byte    = 0;
    errors      = 0;
  endfunction

  function void write_reg(logic [rcsfd_pkg::CFG_INDEX_W-1:0] index,
                          logic [rcsfd_pkg::CFG_DATA_W-1:0] data);
    case (index)
      rcsfd_pkg::CFG_HIGH_RES:  cfg.high_resolution  = data[0];
      rcsfd_pkg::CFG_MIDDLE:    cfg.middle_value     = data[11:0];
      rcsfd_pkg::CFG_CHAN_MAP:  cfg.channel_map      = data[20:0];
      rcsfd_pkg::CFG_GAP_THRES: cfg.gap_threshold_us = data[15:0];
      default: ;
    endcase
  endfunction

  function void decode_frame();
    int          b;
    int unsigned shift;
    logic [7:0]  hi;
    logic [3:0]  id;
    logic [2:0]  dmask;
    shift = cfg.high_resolution ? 3 : 2;
    dmask = cfg.high_resolution ? 3'h7 : 3'h3;
    for (b = 3; b < FRAME_LEN; b += 2) begin
      hi = frame_bytes[b-1];
      id = 4'(hi >> shift);
      if (id < NUM_CHANNELS) chan_words[id] = {hi[2:0] & dmask, frame_bytes[b]};
    end
    frame_ready = 0;
  endfunction

  function void accept_item(rcsfd_pkg::item_t it);
    readout_t    r;
    logic [31:0] gap;
    logic [2:0]  slot;
    logic [10:0] word;
    r.value = '0;
    r.done  = 1'b0;
    if (it.is_read == rcsfd_pkg::OP_BYTE) begin
      gap        = it.time_us - last_stamp;
      any_byte   = 1;
      last_stamp = it.time_us;
      if (gap > cfg.gap_threshold_us) wr_pos = 0;
      frame_bytes[wr_pos] = it.rx_byte;
      if (wr_pos == FRAME_LEN - 1) begin
        frame_ready = 1;
        r.done = 1'b1;
      end else begin
        wr_pos++;
      end
    end else begin
      if (frame_ready) decode_frame();
      r.value = cfg.middle_value;
      if (any_byte && it.channel < NUM_CHANNELS && it.channel < rcsfd_pkg::MAP_FIELDS) begin
        slot = cfg.channel_map[3*it.channel +: 3];
        if (slot < NUM_CHANNELS) begin
          word = chan_words[slot];
          if (cfg.high_resolution) word = word >> 1;
          r.value = rcsfd_pkg::BASE_PULSE + {1'b0, word};
        end
      end
    end
    pending_readouts.push_back(r);
  endfunction

  function void compare_readout(logic [11:0] value, logic done);
    readout_t r;
    if (pending_readouts.size() == 0) begin
      errors++;
      $display("%0t: result with no item outstanding, expected none, actual value %0d done %0d",
               $time, value, done);
      return;
    end
    r = pending_readouts.pop_front();
    if (value !== r.value) begin
      errors++;
      $display("%0t: channel_value mismatch, expected %0d, actual %0d", $time, r.value, value);
    end
    if (done !== r.done) begin
      errors++;
      $display("%0t: frame_done mismatch, expected %0d, actual %0d", $time, r.done, done);
    end
  endfunction
endclass

module testbench;
  import rcsfd_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int PHASES = 9;
  localparam int ITEMS_PER_PHASE = 50;
  localparam logic [CFG_INDEX_W-1:0] CFG_UNUSED_INDEX = 8'd4;
  localparam logic [CFG_INDEX_W-1:0] CFG_TOP_INDEX = 8'hFF;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   item_valid = 1'b0;
  logic                   item_stall;
  logic                   operation = OP_BYTE;
  logic [7:0]             rx_byte = '0;
  logic [31:0]            time_us = '0;
  logic [3:0]             channel = '0;
  logic                   result_valid;
  logic                   result_stall = 1'b0;
  logic [11:0]            channel_value;
  logic                   frame_done;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;

  channel_readout_predictor predictor;
  logic [31:0] now_us = '0;
  int sender_idle_pct = 0;
  int receiver_stall_pct = 0;
  int cycle_count = 0;
  int items_sent = 0;

  rc_satellite_frame_decoder_top u_top (
    .clk           (clk),
    .rst           (rst),
    .item_valid    (item_valid),
    .item_stall    (item_stall),
    .operation     (operation),
    .rx_byte       (rx_byte),
    .time_us       (time_us),
    .channel       (channel),
    .result_valid  (result_valid),
    .result_stall  (result_stall),
    .channel_value (channel_value),
    .frame_done    (frame_done),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("[rc_satellite_frame_decoder_top] ERROR");
      $finish;
    end
  end

  always @(negedge clk) begin
    result_stall <= ($urandom_range(99) < receiver_stall_pct);
  end

  always @(posedge clk) begin : watch
    item_t seen;
    if (!rst) begin
      if (cfg_valid && cfg_ready) predictor.write_reg(cfg_index, cfg_data);
      if (item_valid && !item_stall) begin
        seen = '{operation, rx_byte, time_us, channel};
        predictor.accept_item(seen);
      end
      if (result_valid && !result_stall) predictor.compare_readout(channel_value, frame_done);
    end
  end

  function automatic logic [3:0] pick_channel();
    return ($urandom_range(4) == 0) ? 4'($urandom_range(15, 7)) : 4'($urandom_range(6));
  endfunction

  function automatic logic [31:0] hold_delta(logic [31:0] thr);
    return ($urandom_range(3) == 0) ? thr : $urandom_range(thr);
  endfunction

  task automatic send_item(logic op, logic [7:0] b, logic [31:0] t, logic [3:0] ch);
    while ($urandom_range(99) < sender_idle_pct) begin
      @(negedge clk);
      item_valid <= 1'b0;
    end
    @(negedge clk);
    item_valid <= 1'b1;
    operation  <= op;
    rx_byte    <= b;
    time_us    <= t;
    channel    <= ch;
    @(posedge clk);
    while (item_stall) @(posedge clk);
    items_sent++;
  endtask

  task automatic send_byte(logic [7:0] b, logic [31:0] delta);
    now_us = now_us + delta;
    send_item(OP_BYTE, b, now_us, 4'($urandom));
  endtask

  task automatic send_read(logic [3:0] ch);
    send_item(OP_READ, 8'($urandom), $urandom, ch);
  endtask

  task automatic drain();
    @(negedge clk);
    item_valid <= 1'b0;
    while (predictor.pending_readouts.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_INDEX_W-1:0] index, logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= index;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic configure(logic hr, logic [11:0] mid, logic [20:0] map, logic [15:0] gap);
    write_reg(CFG_HIGH_RES, {$urandom} & ~32'h1 | {31'h0, hr});
    write_reg(CFG_MIDDLE, {20'h0, mid});
    write_reg(CFG_CHAN_MAP, {11'h0, map});
    write_reg(CFG_GAP_THRES, {16'h0, gap});
  endtask

  // Byte 0 opens the frame with a gap above the threshold; the rest follow
  // within it. Bytes past the end keep overwriting the last position.
  task automatic send_frame(int n_bytes, int extra);
    logic [31:0] thr;
    logic [7:0]  hi;
    logic [3:0]  id;
    int          i;
    thr = {16'h0, predictor.cfg.gap_threshold_us};
    for (i = 0; i < n_bytes + extra; i++) begin
      if ($urandom_range(9) == 0) send_read(pick_channel());
      if (i == 0) begin
        send_byte(8'($urandom),
                  thr + 1 + (($urandom_range(3) == 0) ? 0 : $urandom_range(70000)));
      end else if (i >= 2 && i < 16 && i % 2 == 0) begin
        hi = 8'($urandom_range(255));
        id = ($urandom_range(9) < 8) ? 4'($urandom_range(6)) : 4'($urandom_range(15, 7));
        if (predictor.cfg.high_resolution) hi[6:3] = id;
        else hi[5:2] = id;
        send_byte(hi, hold_delta(thr));
      end else begin
        send_byte(8'($urandom), hold_delta(thr));
      end
    end
  endtask

  initial begin
    int          k;
    int          start;
    int          pick;
    logic [3:0]  id;
    predictor = new();
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    sender_idle_pct = 19;
    receiver_stall_pct = 51;
    write_reg(CFG_UNUSED_INDEX, $urandom);
    write_reg(CFG_TOP_INDEX, $urandom);

    send_read(4'd0);
    send_read(4'd15);
    now_us = 32'hFFFF_FFF7;
    send_byte(8'h00, 1);
    send_byte(8'hFF, 1);
    for (k = 0; k < 7; k++) begin
      id = (k == 6) ? 4'hF : k[3:0];
      send_byte((k % 2) ? {1'b0, id, 3'b000} : {1'b1, id, 3'b111}, 1);
      send_byte((k % 2) ? 8'h00 : 8'hFF, 1);
    end
    send_byte(8'hA5, 1);
    drain();
    send_read(4'd0);
    send_read(4'd3);
    send_read(4'd6);
    send_read(4'd7);
    send_read(4'd15);
    send_read(4'd5);
    drain();

    for (k = 0; k < PHASES; k++) begin
      if (k < 3) begin
        sender_idle_pct = 19;
        receiver_stall_pct = 51;
      end else if (k < 6) begin
        sender_idle_pct = 51;
        receiver_stall_pct = 19;
      end else begin
        sender_idle_pct = 0;
        receiver_stall_pct = 0;
      end
      case (k)
        0: configure(1'b0, 12'd4095, 21'($urandom_range(21'h1FFFFF)), 16'd0);
        1: configure(1'b1, 12'd0, 21'h1FFFFF, 16'hFFFF);
        2: configure(1'b0, 12'($urandom_range(4095)), 21'd0, 16'($urandom_range(20000)));
        default: configure(1'($urandom_range(1)), 12'($urandom_range(4095)),
                           21'($urandom_range(21'h1FFFFF)),
                           ($urandom_range(3) == 0) ? 16'hFFFF : 16'($urandom_range(20000)));
      endcase
      now_us = $urandom;
      start = items_sent;
      while (items_sent - start < ITEMS_PER_PHASE) begin
        pick = $urandom_range(99);
        if (pick < 65) begin
          send_frame(16, $urandom_range(2));
          repeat ($urandom_range(1, 4)) send_read(pick_channel());
        end else if (pick < 80) begin
          send_frame($urandom_range(1, 15), 0);
        end else if (pick < 90) begin
          repeat ($urandom_range(1, 3)) send_byte(8'($urandom), $urandom);
        end else begin
          repeat ($urandom_range(1, 4)) send_read(pick_channel());
        end
      end
      drain();
    end

    if (predictor.errors == 0 && predictor.pending_readouts.size() == 0) begin
      $display("[rc_satellite_frame_decoder_top] OK");
    end else begin
      $display("[rc_satellite_frame_decoder_top] ERROR");
    end
    $finish;
  end
endmodule
